FILE: hw/rtl/pfa_pkg.sv
// Package for the page free-list allocator: field widths, command and status
// codes, state encoding and the result record. No dependencies.
`default_nettype none

package pfa_pkg;

  localparam int ADDR_W       = 64;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int FREE_COUNT_W = 13;

  localparam int POOL_DEPTH_DEFAULT = 4096;

  // Page size is fixed to a power of two so alignment is a mask.
  localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'd4096;
  localparam logic [ADDR_W-1:0] PAGE_MASK  = PAGE_BYTES - 64'd1;

  localparam logic [ADDR_W-1:0] FLOOR_RESET = 64'h0000_0000_0040_0000;

  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REGION = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_REG_SUM,
    S_REG_CLIP,
    S_REG_ALIGN,
    S_REG_WALK,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       page_address;
    logic [FREE_COUNT_W-1:0] free_count;
    logic [STATUS_W-1:0]     status;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pfa_if.sv
// Channel interfaces of the page free-list allocator: command, result and
// configuration write. Depends on pfa_pkg.
`default_nettype none

interface pfa_cmd_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] region_length;

  modport source (output valid, command, address, region_length, input ready);
  modport sink   (input valid, command, address, region_length, output ready);
endinterface

interface pfa_res_if import pfa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ADDR_W-1:0]       page_address;
  logic [FREE_COUNT_W-1:0] free_count;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, page_address, free_count, status, input ready);
  modport sink   (input valid, page_address, free_count, status, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/page_free_list_allocator.sv
// Page free-list allocator: LIFO stack of page addresses held in one RAM.
// Free, unused command and allocate-on-empty answer straight from idle; allocate
// reads the RAM first; add-region runs capture, sum, clip and align, then the page
// walk and a closing step, or ends at clip when the region lies wholly under the floor.
// Throughput: one item at a time; the page walk pushes one page per cycle (RAM write port).
// Reset (sync, active high): count 0, floor 0x400000; stack RAM not cleared.
`default_nettype none

module page_free_list_allocator import pfa_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  pfa_cmd_if.sink    cmd,
  pfa_res_if.source  res,
  pfa_cfg_if.sink    cfg
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  // Control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             out_valid;

  // Payload registers
  logic [ADDR_W-1:0] floor;
  logic [ADDR_W-1:0] cur;      // region base, then clipped and aligned base, then walk pointer
  logic [ADDR_W-1:0] len;
  logic [ADDR_W-1:0] end_r;    // wrapping region end, unchanged by clip and align
  logic              below;    // base sat under the floor
  res_t              out_res;
  res_t              hold_res; // finished result parked while output is busy

  // Combinational
  logic              in_ready, in_fire, out_free, full;
  logic              fin;
  res_t              fin_res;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [ADDR_W-1:0] wr_data, rd_data;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] nxt;

  assign in_fire  = cmd.valid && in_ready;
  assign out_free = !out_valid || res.ready;
  assign full     = (count == CNT_W'(POOL_DEPTH));
  assign cnt_m1   = count - CNT_W'(1);
  assign nxt      = cur + PAGE_BYTES;

  // ---- stack memory ----
  pfa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---- FSM outputs and stack ops ----
  always_comb begin
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count[IDX_W-1:0];
    wr_data    = cmd.address;
    rd_en      = 1'b0;
    rd_addr    = cnt_m1[IDX_W-1:0];
    count_next = count;
    fin        = 1'b0;
    fin_res    = '{page_address: '0, free_count: '0, status: ST_OK};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          unique case (cmd.command)
            CMD_FREE: begin
              fin = 1'b1;
              if (full) begin
                fin_res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_ALLOC: begin
              if (count == '0) begin
                fin            = 1'b1;
                fin_res.status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = cnt_m1;
              end
            end
            CMD_REGION: begin
              // captured below, walk follows
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        fin                  = 1'b1;
        fin_res.page_address = rd_data;
      end
      S_REG_CLIP: begin
        // whole region under the floor: nothing to push
        if (below && (end_r <= floor)) begin
          fin = 1'b1;
        end
      end
      S_REG_WALK: begin
        if (nxt <= end_r) begin
          if (full) begin
            fin            = 1'b1;
            fin_res.status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_data    = cur;
            count_next = count + CNT_W'(1);
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_REG_SUM, S_REG_ALIGN, S_WAIT: begin
      end
      default: begin
      end
    endcase
    fin_res.free_count = FREE_COUNT_W'(count_next);
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (cmd.command == CMD_REGION)) begin
          state_next = S_REG_SUM;
        end else if (in_fire && (cmd.command == CMD_ALLOC) && (count != '0)) begin
          state_next = S_ALLOC_RD;
        end
      end
      S_REG_SUM:   state_next = S_REG_CLIP;
      S_REG_CLIP:  state_next = S_REG_ALIGN;
      S_REG_ALIGN: state_next = S_REG_WALK;
      S_WAIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_ALLOC_RD, S_REG_WALK: begin
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) begin
      state_next = out_free ? S_IDLE : S_WAIT;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      floor     <= FLOOR_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((fin || (state == S_WAIT)) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        floor <= cfg.data;
      end
    end
  end

  // ---- region datapath and result payload ----
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cur <= cmd.address;
          len <= cmd.region_length;
        end
      end
      S_REG_SUM: begin
        end_r <= cur + len;
        below <= (cur < floor);
      end
      S_REG_CLIP: begin
        if (below) begin
          cur <= floor;
        end
      end
      S_REG_ALIGN: begin
        cur <= (cur + PAGE_MASK) & ~PAGE_MASK;
      end
      S_REG_WALK: begin
        if (wr_en) begin
          cur <= nxt;
        end
      end
      S_ALLOC_RD, S_WAIT: begin
      end
      default: begin
      end
    endcase

    if (fin && out_free) begin
      out_res <= fin_res;
    end else if ((state == S_WAIT) && out_free) begin
      out_res <= hold_res;
    end
    if (fin && !out_free) begin
      hold_res <= fin_res;
    end
  end

  assign cmd.ready        = in_ready;
  assign cfg.ready        = 1'b1;
  assign res.valid        = out_valid;
  assign res.page_address = out_res.page_address;
  assign res.free_count   = out_res.free_count;
  assign res.status       = out_res.status;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(POOL_DEPTH))
    else $error("free count beyond pool depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("stack write with pool full");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not bump the count");

  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_RD) |-> $past(rd_en))
    else $error("allocate result without a stack read");

endmodule

`default_nettype wire

FILE: hw/rtl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: bench/page_free_list_allocator_checker.sv
// Checker for the page free-list allocator: watches the command, reply and
// floor-write channels, keeps its own page stack and floor, and scores each reply.
// Depends on pfa_pkg and the channel interfaces in pfa_if.
`default_nettype none

module page_free_list_allocator_checker import pfa_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  pfa_cmd_if   cmd,
  pfa_res_if   res,
  pfa_cfg_if   cfg,
  output int   failures,
  output int   pending
);

  localparam int PRINT_CAP = 60;
  localparam int IDX_W     = $clog2(POOL_DEPTH);

  logic [ADDR_W-1:0]       page_stack [POOL_DEPTH];
  logic [FREE_COUNT_W-1:0] stack_fill;
  logic [ADDR_W-1:0]       floor_addr;
  res_t                    pool_replies [$];

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    if (failures < PRINT_CAP) begin
      $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    failures++;
  endtask

  // Returns 1 when the pool is full and the page is dropped.
  function automatic bit push_page(input logic [ADDR_W-1:0] page);
    if (stack_fill >= POOL_DEPTH) return 1'b1;
    page_stack[stack_fill[IDX_W-1:0]] = page;
    stack_fill = stack_fill + 1'b1;
    return 1'b0;
  endfunction

  // Clip at the floor, align up, then walk whole pages; all sums wrap at 64 bits.
  function automatic bit walk_region(input logic [ADDR_W-1:0] base_in,
                                     input logic [ADDR_W-1:0] len_in);
    logic [ADDR_W-1:0] base, len, aligned, p, pend;
    base = base_in;
    len  = len_in;
    if (base < floor_addr) begin
      if (base + len <= floor_addr) return 1'b0;
      len  = len - (floor_addr - base);
      base = floor_addr;
    end
    aligned = base + ((PAGE_BYTES - base % PAGE_BYTES) % PAGE_BYTES);
    len     = len - (aligned - base);
    p       = aligned;
    pend    = aligned + len;
    while (p + PAGE_BYTES <= pend) begin
      if (push_page(p)) return 1'b1;
      p = p + PAGE_BYTES;
    end
    return 1'b0;
  endfunction

  function automatic res_t pool_step(input logic [CMD_W-1:0] op,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [ADDR_W-1:0] len);
    res_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      CMD_FREE: begin
        if (push_page(addr)) r.status = ST_FULL;
      end
      CMD_ALLOC: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill     = stack_fill - 1'b1;
          r.page_address = page_stack[stack_fill[IDX_W-1:0]];
        end
      end
      CMD_REGION: begin
        if (walk_region(addr, len)) r.status = ST_FULL;
      end
      default: begin
      end
    endcase
    r.free_count = stack_fill;
    return r;
  endfunction

  // Reply beat is scored before the command beat of the same edge is predicted.
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      stack_fill = '0;
      floor_addr = FLOOR_RESET;
      pool_replies.delete();
      failures   = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pool_replies.size() == 0) begin
          report_mismatch("reply with no command outstanding", res.page_address, '0);
        end else begin
          want = pool_replies.pop_front();
          if (res.page_address !== want.page_address)
            report_mismatch("page_address", res.page_address, want.page_address);
          if (res.free_count !== want.free_count)
            report_mismatch("free_count", ADDR_W'(res.free_count), ADDR_W'(want.free_count));
          if (res.status !== want.status)
            report_mismatch("status", ADDR_W'(res.status), ADDR_W'(want.status));
        end
      end
      if (cfg.valid && cfg.ready) floor_addr = cfg.data;
      if (cmd.valid && cmd.ready)
        pool_replies.push_back(pool_step(cmd.command, cmd.address, cmd.region_length));
    end
    pending <= pool_replies.size();
  end

endmodule

`default_nettype wire

FILE: bench/page_free_list_allocator_tb.sv
// Testbench top for the page free-list allocator: clock, reset, command and
// floor stimulus, reply back-pressure and the verdict. Depends on pfa_pkg,
// pfa_if, the allocator RTL and page_free_list_allocator_checker.
`default_nettype none

module page_free_list_allocator_tb;
  import pfa_pkg::*;

  // Command encoding the block must treat as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Slowest legal run: ~620 items, each with its longest send gap and reply stall,
  // plus every page walk (pushes are bounded by the pool size plus the pops). The
  // limit is several times that.
  localparam int CYCLE_LIMIT   = 500000;
  // Leave room after the drain.
  localparam int SETTLE_CYCLES = 16;

  logic              clk = 1'b0;
  logic              rst;
  int                failures;
  int                pending;
  int                cycles = 0;
  bit                quiet = 1'b0;   // no gaps on either side while set
  logic [ADDR_W-1:0] current_floor;

  pfa_cmd_if cmd_ch ();
  pfa_res_if res_ch ();
  pfa_cfg_if cfg_ch ();

  page_free_list_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  page_free_list_allocator_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg      (cfg_ch),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("page_free_list_allocator test failed");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Reply side: ready high for a short run, then maybe a stall.
  initial begin : reply_sink
    int gap;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // One command beat. Entered just after a rising edge; valid stays high
  // into the next beat when no gap is drawn.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [ADDR_W-1:0] len);
    int gap;
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= op;
    cmd_ch.address       <= addr;
    cmd_ch.region_length <= len;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every reply is back; sampled on the falling
  // edge so the checker's count is settled.
  task automatic wait_for_replies();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Floor writes only ever happen with the block idle.
  task automatic write_floor(input logic [ADDR_W-1:0] value);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.data   <= value;
    current_floor = value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Region bases: either well clear of the floor or straddling it, so the
  // clip path is hit often. Far bases keep the top byte zero so that ordinary
  // regions stay short; bases near a high floor can sit close to the top.
  function automatic logic [ADDR_W-1:0] region_base();
    logic [ADDR_W-1:0] near;
    near = {32'h0, 32'($urandom_range(0, 32'h7FFF))};
    if ($urandom_range(0, 2) == 0) return {8'h0, $urandom, 24'h0} + near;
    if (current_floor >= 64'h8000) return current_floor - 64'h4000 + near;
    return near;
  endfunction

  // Up to four pages, sometimes with a ragged tail.
  function automatic logic [ADDR_W-1:0] region_span();
    logic [ADDR_W-1:0] span;
    span = PAGE_BYTES * $urandom_range(0, 4);
    if ($urandom_range(0, 1) == 0) span = span + $urandom_range(0, 4095);
    return span;
  endfunction

  // Sparse mix is tuned so pops roughly balance pushes and the pool keeps
  // running dry; the crowded mix keeps a full pool dropping pages, with some
  // fully random regions as noise.
  task automatic random_item(input bit crowded);
    int                pick;
    logic [ADDR_W-1:0] a, l;
    pick = $urandom_range(0, 99);
    a    = {$urandom, $urandom};
    l    = {$urandom, $urandom};
    if (pick < (crowded ? 30 : 58)) begin
      send_item(CMD_ALLOC, a, l);
    end else if (pick < (crowded ? 55 : 73)) begin
      send_item(CMD_FREE, ($urandom_range(0, 1) == 0) ? a : (a & ~PAGE_MASK), l);
    end else if (pick < 95) begin
      if (crowded && $urandom_range(0, 4) == 0) send_item(CMD_REGION, a, l);
      else send_item(CMD_REGION, region_base(), region_span());
    end else begin
      send_item(CMD_UNUSED, a, l);
    end
  endtask

  initial begin : stimulus
    rst                  <= 1'b1;
    current_floor        = FLOOR_RESET;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.command       <= CMD_FREE;
    cmd_ch.address       <= '0;
    cmd_ch.region_length <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.data          <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pool, the no-op code, extreme addresses and LIFO order.
    send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(CMD_FREE, '0, '0);
    send_item(CMD_FREE, '1, '1);
    send_item(CMD_FREE, 64'h5555_5555_5555_5555, '0);
    send_item(CMD_FREE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    repeat (5) send_item(CMD_ALLOC, '0, '0);
    // Region cases at the reset floor.
    send_item(CMD_REGION, 64'h0, 64'h1000);               // wholly below the floor
    send_item(CMD_REGION, 64'h3F_F000, 64'h3000);         // straddles: clipped to two pages
    send_item(CMD_REGION, 64'h1000_0123, 64'h3000);       // unaligned base
    send_item(CMD_REGION, 64'h2000_0000, 64'h0);          // zero length
    send_item(CMD_REGION, '1, 64'h3001);                  // alignment wraps to page zero
    send_item(CMD_REGION, 64'h1000, 64'h0 - 64'h1000);    // end wraps to zero, below floor
    send_item(CMD_REGION, 64'h1000, 64'h50_0000 - 64'h1000); // straddles: clipped at the floor
    repeat (2) send_item(CMD_ALLOC, '0, '0);

    // Sparse pool at the reset floor.
    repeat (150) random_item(1'b0);

    wait_for_replies();
    write_floor('0);
    repeat (100) random_item(1'b0);

    wait_for_replies();
    write_floor('1);
    repeat (80) random_item(1'b0);

    // Odd, unaligned floor with both sides flat out.
    wait_for_replies();
    write_floor({24'h0, $urandom, 8'($urandom_range(0, 255))});
    quiet = 1'b1;
    repeat (100) random_item(1'b0);
    quiet = 1'b0;

    // Full pool: fill, free into it, partial region, region with no room.
    wait_for_replies();
    write_floor(FLOOR_RESET);
    send_item(CMD_REGION, 64'h1_0000_0000, 64'h0000_1000_0000_0000);
    send_item(CMD_FREE, 64'h123, '0);
    repeat (3) send_item(CMD_ALLOC, '0, '0);
    send_item(CMD_REGION, 64'h8000_0000, 64'h5000);
    send_item(CMD_REGION, 64'h9000_0000, 64'h2000);

    wait_for_replies();
    write_floor({$urandom, $urandom});
    repeat (150) random_item(1'b1);

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("page_free_list_allocator test passed");
    end else begin
      $display("page_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
